/* rtl/core/tcpg_pkg.sv */
// -----------------------------------------------------------------------------
// tcpg_pkg
// Shared types, constants and the reset palette of the text cell pixel
// generator.
// -----------------------------------------------------------------------------
`default_nettype none

package tcpg_pkg;

   localparam int DEF_MAX_GLYPH_LINES = 32;
   localparam int DEF_GLYPH_COUNT     = 256;

   localparam int CODE_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int LINE_W      = 5;
   localparam int GLYPH_W     = 8;
   localparam int PAL_IDX_W   = 4;
   localparam int COMP_W      = 16;
   localparam int COLUMN_W    = 3;
   localparam int PAL_ENTRIES = 16;
   localparam int MODE_W      = 2;

   localparam logic [COMP_W-1:0]    LEVEL_COLOR  = 16'hAAAA;
   localparam logic [COMP_W-1:0]    LEVEL_BRIGHT = 16'h5555;
   localparam logic [COMP_W-1:0]    ALPHA_OPAQUE = 16'hFFFF;
   localparam logic [PAL_IDX_W-1:0] BROWN_INDEX  = 4'd6;
   localparam logic [COLUMN_W-1:0]  LAST_COLUMN  = 3'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_RENDER        = 2'd0,
      MODE_GLYPH_WRITE   = 2'd1,
      MODE_PALETTE_WRITE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] alpha;
   } color_type;

   typedef struct packed {
      logic                 en;
      logic [PAL_IDX_W-1:0] index;
      color_type            color;
   } pal_write_type;

   typedef struct packed {
      logic              load;
      logic              in_range;
      logic [ATTR_W-1:0] attribute;
   } line_load_type;

   // One component of the standard sixteen-color palette.
   function automatic logic [COMP_W-1:0] cga_level(input logic [PAL_IDX_W-1:0] idx,
                                                   input logic color_bit);
      logic [COMP_W-1:0] level;
      level = '0;
      if (color_bit) begin
         level = level | LEVEL_COLOR;
      end
      if (idx[3]) begin
         level = level | LEVEL_BRIGHT;
      end
      return level;
   endfunction

   function automatic color_type cga_color(input logic [PAL_IDX_W-1:0] idx);
      color_type c;
      c.red   = cga_level(idx, idx[2]);
      c.green = cga_level(idx, idx[1]);
      c.blue  = cga_level(idx, idx[0]);
      c.alpha = ALPHA_OPAQUE;
      // Brown takes a reduced green instead of dark yellow.
      if (idx == BROWN_INDEX) begin
         c.green = LEVEL_BRIGHT;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tcpg_ram.sv */
// -----------------------------------------------------------------------------
// tcpg_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module tcpg_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/tcpg_palette.sv */
// -----------------------------------------------------------------------------
// tcpg_palette
// Sixteen-entry RGBA palette in flip-flops, reset to the standard colors,
// one write port and one combinational read port.
// -----------------------------------------------------------------------------
`default_nettype none

module tcpg_palette (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcpg_pkg::pal_write_type       wr,
   input  wire logic [tcpg_pkg::PAL_IDX_W-1:0] rd_index,
   output tcpg_pkg::color_type                rd_color
);

   tcpg_pkg::color_type pal_ff [tcpg_pkg::PAL_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcpg_pkg::PAL_ENTRIES; i++) begin
            pal_ff[i] <= tcpg_pkg::cga_color(tcpg_pkg::PAL_IDX_W'(i));
         end
      end else if (wr.en) begin
         pal_ff[wr.index] <= wr.color;
      end
   end

   assign rd_color = pal_ff[rd_index];

endmodule

`default_nettype wire

/* rtl/core/tcpg_pixel_out.sv */
// -----------------------------------------------------------------------------
// tcpg_pixel_out
// Glyph shifter, column counter and result register. Turns one glyph byte
// and attribute into eight pixel words, one per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module tcpg_pixel_out (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tcpg_pkg::line_load_type         load,
   input  wire logic [tcpg_pkg::GLYPH_W-1:0]    glyph_data,
   input  wire tcpg_pkg::color_type             pal_color,
   output logic      [tcpg_pkg::PAL_IDX_W-1:0]  pal_index,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_red,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_green,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_blue,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_alpha,
   output logic      [tcpg_pkg::COLUMN_W-1:0]   rsp_pixel_column,
   output logic                                 rsp_last_pixel
);

   logic                              gen_ff, gen_in;
   logic [tcpg_pkg::COLUMN_W-1:0]     col_ff, col_in;
   logic [tcpg_pkg::GLYPH_W-1:0]      shift_ff;
   logic [tcpg_pkg::ATTR_W-1:0]       attr_ff;
   logic                              range_ff;
   logic [tcpg_pkg::GLYPH_W-1:0]      bits_cur;
   logic                              col_last;

   logic                              rsp_valid_ff;
   tcpg_pkg::color_type               rsp_color_ff;
   logic [tcpg_pkg::COLUMN_W-1:0]     rsp_column_ff;
   logic                              rsp_last_ff;

   assign col_last = (col_ff == tcpg_pkg::LAST_COLUMN);
   assign busy     = gen_ff & ~col_last;

   // Column zero takes the byte straight from the glyph RAM; later columns
   // come from the shifter.
   always_comb begin
      if (col_ff == '0) begin
         bits_cur = range_ff ? glyph_data : '0;
      end else begin
         bits_cur = shift_ff;
      end
      pal_index = bits_cur[tcpg_pkg::GLYPH_W-1] ? attr_ff[3:0] : attr_ff[7:4];
      gen_in    = load.load | (gen_ff & ~col_last);
      col_in    = gen_ff ? 3'(col_ff + 3'd1) : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         col_ff       <= col_in;
         rsp_valid_ff <= gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         attr_ff  <= load.attribute;
         range_ff <= load.in_range;
      end
      if (gen_ff) begin
         shift_ff      <= {bits_cur[tcpg_pkg::GLYPH_W-2:0], 1'b0};
         rsp_color_ff  <= pal_color;
         rsp_column_ff <= col_ff;
         rsp_last_ff   <= col_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_red    = rsp_color_ff.red;
   assign rsp_pixel_green  = rsp_color_ff.green;
   assign rsp_pixel_blue   = rsp_color_ff.blue;
   assign rsp_pixel_alpha  = rsp_color_ff.alpha;
   assign rsp_pixel_column = rsp_column_ff;
   assign rsp_last_pixel   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A new line is only loaded when no line is in progress or the previous one is on its last column.
   a_load_not_busy: assert property (@(posedge clock) disable iff (reset)
      load.load |-> !busy)
      else $error("line loaded while a line is still in progress");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load.load |=> gen_ff && col_ff == '0)
      else $error("line load did not start at column zero");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      gen_ff && !col_last |=> gen_ff && col_ff == 3'($past(col_ff) + 3'd1))
      else $error("column counter skipped or stalled");

   a_last_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |=> !rsp_valid || rsp_pixel_column == '0)
      else $error("word after the last pixel is not a new line");
`endif

endmodule

`default_nettype wire

/* rtl/core/text_cell_pixel_generator.sv */
// -----------------------------------------------------------------------------
// text_cell_pixel_generator
// Text-mode character generator: glyph RAM, sixteen-color palette and
// a pixel shifter that gives eight RGBA pixel words per cell line.
//
//   channel   ports                     handshake
//   request   start, busy, req_*        taken when start & !busy
//   response  rsp_valid, rsp_*          one word per rsp_valid cycle
//
// A render request reads its glyph byte into the glyph RAM read register;
// the shifter then steps through the columns and the result register gives
// the pixel words, one per cycle. The next request can be taken while the
// shifter is on the last column. Glyph and palette writes give no word.
// Synchronous reset restores the standard palette; the glyph RAM is not
// cleared and must be written before use. The receiver cannot stall.
// -----------------------------------------------------------------------------
`default_nettype none

module text_cell_pixel_generator #(
   parameter int MAX_GLYPH_LINES = tcpg_pkg::DEF_MAX_GLYPH_LINES,
   parameter int GLYPH_COUNT     = tcpg_pkg::DEF_GLYPH_COUNT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [tcpg_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [tcpg_pkg::CODE_W-1:0]     req_char_code,
   input  wire logic [tcpg_pkg::ATTR_W-1:0]     req_attribute,
   input  wire logic [tcpg_pkg::LINE_W-1:0]     req_glyph_line,
   input  wire logic [tcpg_pkg::GLYPH_W-1:0]    req_font_bits,
   input  wire logic [tcpg_pkg::PAL_IDX_W-1:0]  req_palette_index,
   input  wire logic [tcpg_pkg::COMP_W-1:0]     req_red_in,
   input  wire logic [tcpg_pkg::COMP_W-1:0]     req_green_in,
   input  wire logic [tcpg_pkg::COMP_W-1:0]     req_blue_in,
   input  wire logic [tcpg_pkg::COMP_W-1:0]     req_alpha_in,
   output logic                                 rsp_valid,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_red,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_green,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_blue,
   output logic      [tcpg_pkg::COMP_W-1:0]     rsp_pixel_alpha,
   output logic      [tcpg_pkg::COLUMN_W-1:0]   rsp_pixel_column,
   output logic                                 rsp_last_pixel
);

   localparam int GLYPH_DEPTH = GLYPH_COUNT * MAX_GLYPH_LINES;
   localparam int GA_W        = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
   localparam int SUM_W       = 16;

   logic                          accept;
   logic                          do_render;
   logic                          do_glyph_wr;
   logic                          do_pal_wr;
   logic                          in_range;
   logic [SUM_W-1:0]              glyph_sum;
   logic [GA_W-1:0]               glyph_addr;
   logic [tcpg_pkg::GLYPH_W-1:0]  glyph_data;
   logic [tcpg_pkg::PAL_IDX_W-1:0] pal_index;
   tcpg_pkg::color_type           pal_color;
   tcpg_pkg::pal_write_type       pal_wr;
   tcpg_pkg::line_load_type       line_load;

   assign accept = start & ~busy;

   always_comb begin
      do_render    = 1'b0;
      do_glyph_wr  = 1'b0;
      do_pal_wr    = 1'b0;
      if (accept) begin
         unique case (req_mode)
            tcpg_pkg::MODE_RENDER:        do_render   = 1'b1;
            tcpg_pkg::MODE_GLYPH_WRITE:   do_glyph_wr = 1'b1;
            tcpg_pkg::MODE_PALETTE_WRITE: do_pal_wr   = 1'b1;
            default: ;
         endcase
      end
   end

   // Codes or lines beyond the store are dropped on write and read as blank.
   assign in_range = ({1'b0, req_char_code} < 9'(GLYPH_COUNT)) &&
                     ({3'b000, req_glyph_line} < 8'(MAX_GLYPH_LINES));
   assign glyph_sum = SUM_W'(req_char_code) * SUM_W'(MAX_GLYPH_LINES) +
                      SUM_W'(req_glyph_line);
   assign glyph_addr = GA_W'(glyph_sum);

   assign pal_wr = {do_pal_wr, req_palette_index,
                    req_red_in, req_green_in, req_blue_in, req_alpha_in};

   assign line_load = {do_render, in_range, req_attribute};

   tcpg_ram #(
      .WIDTH  (tcpg_pkg::GLYPH_W),
      .DEPTH  (GLYPH_DEPTH),
      .ADDR_W (GA_W)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (do_glyph_wr & in_range),
      .wr_addr (glyph_addr),
      .wr_data (req_font_bits),
      .rd_en   (do_render),
      .rd_addr (glyph_addr),
      .rd_data (glyph_data)
   );

   tcpg_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .rd_index (pal_index),
      .rd_color (pal_color)
   );

   tcpg_pixel_out u_pixel_out (
      .clock            (clock),
      .reset            (reset),
      .load             (line_load),
      .glyph_data       (glyph_data),
      .pal_color        (pal_color),
      .pal_index        (pal_index),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_red    (rsp_pixel_red),
      .rsp_pixel_green  (rsp_pixel_green),
      .rsp_pixel_blue   (rsp_pixel_blue),
      .rsp_pixel_alpha  (rsp_pixel_alpha),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

/* test/text_cell_pixel_generator_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// text_cell_pixel_generator_tb
// Self-checking testbench for the text cell pixel generator. Glyph writes
// and palette writes update a shadow copy of the glyph RAM and the
// palette; unused-mode words are only counted. Each render word predicts
// eight pixel words from that copy. A checker compares every pixel word
// against the oldest prediction. Directed tests come first. Random traffic
// then runs with no sender idling, with heavy idling and with light idling.
// -----------------------------------------------------------------------------

module text_cell_pixel_generator_tb;

   localparam int GLYPH_LINES    = tcpg_pkg::DEF_MAX_GLYPH_LINES;
   localparam int GLYPH_CODES    = tcpg_pkg::DEF_GLYPH_COUNT;
   localparam int GLYPH_DEPTH    = GLYPH_LINES * GLYPH_CODES;
   localparam int MAX_GAP        = 40;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 500;
   localparam logic [tcpg_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [tcpg_pkg::MODE_W-1:0]    mode;
      logic [tcpg_pkg::CODE_W-1:0]    char_code;
      logic [tcpg_pkg::ATTR_W-1:0]    attribute;
      logic [tcpg_pkg::LINE_W-1:0]    glyph_line;
      logic [tcpg_pkg::GLYPH_W-1:0]   font_bits;
      logic [tcpg_pkg::PAL_IDX_W-1:0] palette_index;
      tcpg_pkg::color_type            color;
   } req_word_type;

   typedef struct {
      tcpg_pkg::color_type           color;
      logic [tcpg_pkg::COLUMN_W-1:0] column;
      logic                          last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [tcpg_pkg::MODE_W-1:0]    req_mode;
   logic [tcpg_pkg::CODE_W-1:0]    req_char_code;
   logic [tcpg_pkg::ATTR_W-1:0]    req_attribute;
   logic [tcpg_pkg::LINE_W-1:0]    req_glyph_line;
   logic [tcpg_pkg::GLYPH_W-1:0]   req_font_bits;
   logic [tcpg_pkg::PAL_IDX_W-1:0] req_palette_index;
   logic [tcpg_pkg::COMP_W-1:0]    req_red_in;
   logic [tcpg_pkg::COMP_W-1:0]    req_green_in;
   logic [tcpg_pkg::COMP_W-1:0]    req_blue_in;
   logic [tcpg_pkg::COMP_W-1:0]    req_alpha_in;
   logic                           rsp_valid;
   logic [tcpg_pkg::COMP_W-1:0]    rsp_pixel_red;
   logic [tcpg_pkg::COMP_W-1:0]    rsp_pixel_green;
   logic [tcpg_pkg::COMP_W-1:0]    rsp_pixel_blue;
   logic [tcpg_pkg::COMP_W-1:0]    rsp_pixel_alpha;
   logic [tcpg_pkg::COLUMN_W-1:0]  rsp_pixel_column;
   logic                           rsp_last_pixel;

   // Shadow copy of the block's storage, updated as each word is accepted.
   logic [tcpg_pkg::GLYPH_W-1:0] shadow_glyphs [GLYPH_DEPTH];
   bit                           glyph_written [GLYPH_DEPTH];
   int unsigned                  written_addrs [$];
   tcpg_pkg::color_type          shadow_palette [tcpg_pkg::PAL_ENTRIES];
   pixel_type                    expected_pixels [$];

   int error_count     = 0;
   int sender_idle_pct = 0;
   int cell_lines      = 0;
   int glyph_writes    = 0;
   int palette_writes  = 0;
   int unused_words    = 0;
   int pixels_checked  = 0;
   int quiet_cycles    = 0;

   text_cell_pixel_generator #(
      .MAX_GLYPH_LINES(GLYPH_LINES),
      .GLYPH_COUNT    (GLYPH_CODES)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_char_code    (req_char_code),
      .req_attribute    (req_attribute),
      .req_glyph_line   (req_glyph_line),
      .req_font_bits    (req_font_bits),
      .req_palette_index(req_palette_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_red    (rsp_pixel_red),
      .rsp_pixel_green  (rsp_pixel_green),
      .rsp_pixel_blue   (rsp_pixel_blue),
      .rsp_pixel_alpha  (rsp_pixel_alpha),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (error_count < 40) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic reset_shadow_palette();
      logic [tcpg_pkg::PAL_IDX_W-1:0] n;
      logic [tcpg_pkg::COMP_W-1:0]    bright;
      for (int i = 0; i < tcpg_pkg::PAL_ENTRIES; i++) begin
         n = i[tcpg_pkg::PAL_IDX_W-1:0];
         bright = n[3] ? tcpg_pkg::LEVEL_BRIGHT : 16'h0;
         shadow_palette[i].red   = (n[2] ? tcpg_pkg::LEVEL_COLOR : 16'h0) | bright;
         shadow_palette[i].green = (n[1] ? tcpg_pkg::LEVEL_COLOR : 16'h0) | bright;
         shadow_palette[i].blue  = (n[0] ? tcpg_pkg::LEVEL_COLOR : 16'h0) | bright;
         shadow_palette[i].alpha = tcpg_pkg::ALPHA_OPAQUE;
         if (n == tcpg_pkg::BROWN_INDEX) begin
            shadow_palette[i].green = tcpg_pkg::LEVEL_BRIGHT;
         end
      end
   endtask

   // Updates the shadow storage for one accepted word; a render word
   // queues the eight pixel words it should produce.
   task automatic predict_pixels(input req_word_type w);
      int unsigned                    addr;
      bit                             in_range;
      logic [tcpg_pkg::GLYPH_W-1:0]   bits;
      logic [tcpg_pkg::PAL_IDX_W-1:0] idx;
      pixel_type                      p;
      in_range = (w.char_code < GLYPH_CODES) && (w.glyph_line < GLYPH_LINES);
      addr = w.char_code * GLYPH_LINES + w.glyph_line;
      unique case (w.mode)
         tcpg_pkg::MODE_GLYPH_WRITE: begin
            glyph_writes++;
            if (in_range) begin
               shadow_glyphs[addr] = w.font_bits;
               if (!glyph_written[addr]) begin
                  glyph_written[addr] = 1'b1;
                  written_addrs.push_back(addr);
               end
            end
         end
         tcpg_pkg::MODE_PALETTE_WRITE: begin
            palette_writes++;
            shadow_palette[w.palette_index] = w.color;
         end
         tcpg_pkg::MODE_RENDER: begin
            cell_lines++;
            // A line or code outside the glyph RAM renders as background.
            bits = in_range ? shadow_glyphs[addr] : '0;
            for (int k = 0; k < 8; k++) begin
               idx = bits[7-k] ? w.attribute[3:0] : w.attribute[7:4];
               p.color  = shadow_palette[idx];
               p.column = k[tcpg_pkg::COLUMN_W-1:0];
               p.last   = (p.column == tcpg_pkg::LAST_COLUMN);
               expected_pixels.push_back(p);
            end
         end
         default: begin
            unused_words++;
         end
      endcase
   endtask

   function automatic logic [tcpg_pkg::COMP_W-1:0] random_component();
      unique case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return tcpg_pkg::COMP_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.mode          = tcpg_pkg::MODE_W'($urandom_range(3));
      w.char_code     = tcpg_pkg::CODE_W'($urandom_range(255));
      w.attribute     = tcpg_pkg::ATTR_W'($urandom_range(255));
      w.glyph_line    = tcpg_pkg::LINE_W'($urandom_range(31));
      w.font_bits     = tcpg_pkg::GLYPH_W'($urandom_range(255));
      w.palette_index = tcpg_pkg::PAL_IDX_W'($urandom_range(15));
      w.color.red     = random_component();
      w.color.green   = random_component();
      w.color.blue    = random_component();
      w.color.alpha   = random_component();
      return w;
   endfunction

   // Holds one word on the request ports until it is taken, then idles the
   // sender for a random number of cycles.
   task automatic send_word(input req_word_type w);
      int gap;
      start             <= 1'b1;
      req_mode          <= w.mode;
      req_char_code     <= w.char_code;
      req_attribute     <= w.attribute;
      req_glyph_line    <= w.glyph_line;
      req_font_bits     <= w.font_bits;
      req_palette_index <= w.palette_index;
      req_red_in        <= w.color.red;
      req_green_in      <= w.color.green;
      req_blue_in       <= w.color.blue;
      req_alpha_in      <= w.color.alpha;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pixels(w);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_glyph(input int code, input int line, input int font);
      req_word_type w;
      w = random_word();
      w.mode       = tcpg_pkg::MODE_GLYPH_WRITE;
      w.char_code  = tcpg_pkg::CODE_W'(code);
      w.glyph_line = tcpg_pkg::LINE_W'(line);
      w.font_bits  = tcpg_pkg::GLYPH_W'(font);
      send_word(w);
   endtask

   task automatic send_render(input int code, input int line, input int attr);
      req_word_type w;
      w = random_word();
      w.mode       = tcpg_pkg::MODE_RENDER;
      w.char_code  = tcpg_pkg::CODE_W'(code);
      w.glyph_line = tcpg_pkg::LINE_W'(line);
      w.attribute  = tcpg_pkg::ATTR_W'(attr);
      send_word(w);
   endtask

   task automatic send_palette(input int index,
                               input logic [tcpg_pkg::COMP_W-1:0] r,
                               input logic [tcpg_pkg::COMP_W-1:0] g,
                               input logic [tcpg_pkg::COMP_W-1:0] b,
                               input logic [tcpg_pkg::COMP_W-1:0] a);
      req_word_type w;
      w = random_word();
      w.mode          = tcpg_pkg::MODE_PALETTE_WRITE;
      w.palette_index = tcpg_pkg::PAL_IDX_W'(index);
      w.color         = '{r, g, b, a};
      send_word(w);
   endtask

   task automatic test_glyph_writes();
      send_glyph(0, 0, 8'hAA);
      send_glyph(255, 31, 8'h55);
      send_glyph(128, 16, 8'hFF);
      send_glyph(1, 1, 8'h00);
   endtask

   // The alternating glyph shows every index once: the low half as
   // background and the high half as foreground across the eight renders.
   task automatic test_reset_palette();
      for (int i = 0; i < 8; i++) begin
         send_render(0, 0, (i << 4) | (15 - i));
      end
   endtask

   task automatic test_glyph_patterns();
      send_render(128, 16, 8'h00);
      send_render(1, 1, 8'hFF);
      send_render(255, 31, 8'hA5);
   endtask

   task automatic test_palette_writes();
      send_palette(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_palette(15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_palette(tcpg_pkg::BROWN_INDEX, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_render(255, 31, 8'hF0);
      send_render(0, 0, 8'h06);
   endtask

   task automatic test_unused_mode();
      req_word_type w;
      w = random_word();
      w.mode = MODE_UNUSED;
      send_word(w);
      send_render(0, 0, 8'h9C);
   endtask

   // Renders only read glyph entries that have been written.
   task automatic test_random_traffic(input int count, input int idle_pct);
      req_word_type w;
      int unsigned  addr;
      int           roll;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         w = random_word();
         roll = $urandom_range(99);
         if (roll < 60) begin
            addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
            w.mode       = tcpg_pkg::MODE_RENDER;
            w.char_code  = tcpg_pkg::CODE_W'(addr / GLYPH_LINES);
            w.glyph_line = tcpg_pkg::LINE_W'(addr % GLYPH_LINES);
         end else if (roll < 85) begin
            w.mode = tcpg_pkg::MODE_GLYPH_WRITE;
         end else if (roll < 97) begin
            w.mode = tcpg_pkg::MODE_PALETTE_WRITE;
         end else begin
            w.mode = MODE_UNUSED;
         end
         send_word(w);
      end
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_valid) begin
         got.color  = '{rsp_pixel_red, rsp_pixel_green, rsp_pixel_blue, rsp_pixel_alpha};
         got.column = rsp_pixel_column;
         got.last   = rsp_last_pixel;
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("pixel word with none expected: rgba %h col %0d",
                                   got.color, got.column));
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.color.red !== want.color.red || got.color.green !== want.color.green ||
                got.color.blue !== want.color.blue ||
                got.color.alpha !== want.color.alpha ||
                got.column !== want.column || got.last !== want.last) begin
               report_error($sformatf("pixel rgba %h col %0d last %b, expected %h col %0d last %b",
                                      got.color, got.column, got.last,
                                      want.color, want.column, want.last));
            end
         end
      end
   end

   // Ends the run if neither a request nor a pixel word moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d pixel words outstanding", expected_pixels.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_mode          <= '0;
      req_char_code     <= '0;
      req_attribute     <= '0;
      req_glyph_line    <= '0;
      req_font_bits     <= '0;
      req_palette_index <= '0;
      req_red_in        <= '0;
      req_green_in      <= '0;
      req_blue_in       <= '0;
      req_alpha_in      <= '0;
      reset_shadow_palette();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_glyph_writes();
      test_reset_palette();
      test_glyph_patterns();
      test_palette_writes();
      test_unused_mode();
      test_random_traffic(70, 0);
      test_random_traffic(70, 80);
      test_random_traffic(70, 10);

      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_error($sformatf("%0d pixel words never arrived", expected_pixels.size()));
      end

      $display("Covered %0d cell lines (%0d pixel words checked), %0d glyph writes,",
               cell_lines, pixels_checked, glyph_writes);
      $display("%0d palette writes and %0d unused-mode words, with and without sender idling.",
               palette_writes, unused_words);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
